// ===== hdl/lcdtw_pkg.sv =====
// shared types, request codes and address helpers for the character lcd text writer
// no dependencies; imported by every module of the block
`default_nettype none

package lcdtw_pkg;

    // request codes
    localparam logic [1:0] REQ_SET_POS  = 2'd0;
    localparam logic [1:0] REQ_TEXT     = 2'd1;
    localparam logic [1:0] REQ_RAW_CMD  = 2'd2;
    localparam logic [1:0] REQ_RAW_DATA = 2'd3;

    // configuration register indexes
    localparam logic [1:0] CFG_ROW_COUNT    = 2'd0;
    localparam logic [1:0] CFG_COLUMN_COUNT = 2'd1;

    localparam logic [2:0] ROW_COUNT_RESET    = 3'd2;
    localparam logic [5:0] COLUMN_COUNT_RESET = 6'd16;
    localparam logic [2:0] ROW_LIMIT          = 3'd4;

    // special characters
    localparam logic [7:0] CHAR_NUL = 8'h00;
    localparam logic [7:0] CHAR_LF  = 8'h0A;
    localparam logic [7:0] CHAR_CR  = 8'h0D;

    localparam logic       RS_CMD        = 1'b0;
    localparam logic       RS_DATA       = 1'b1;
    localparam logic [7:0] CMD_SET_DDRAM = 8'h80;

    // job queue between front and back, depth a power of two
    localparam int JOB_DEPTH   = 2;
    localparam int JOB_PTR_W   = $clog2(JOB_DEPTH);
    localparam int JOB_COUNT_W = $clog2(JOB_DEPTH + 1);

    typedef struct packed {
        logic [1:0] req_type;
        logic [7:0] byte_value;
        logic [5:0] col_pos;
        logic [1:0] row_pos;
    } t_req;

    typedef struct packed {
        logic       reg_select;
        logic [3:0] nibble;
        logic       last_nibble;
    } t_res;

    typedef struct packed {
        logic       rs;
        logic [7:0] value;
    } t_bus_byte;

    // one or two bytes caused by one request
    typedef struct packed {
        logic      two;
        t_bus_byte b0;
        t_bus_byte b1;
    } t_job;

    typedef struct packed {
        logic full;
        logic empty;
    } t_queue_status;

    function automatic logic [6:0] row_base(input logic [1:0] row);
        logic [6:0] base;
        case (row)
            2'd0:    base = 7'h00;
            2'd1:    base = 7'h40;
            2'd2:    base = 7'h14;
            default: base = 7'h54;
        endcase
        return base;
    endfunction

    // row at or past the rows in use (or past the panel) goes back to row 0
    function automatic logic [1:0] fold_row(input logic [2:0] row, input logic [2:0] rows);
        logic [1:0] res;
        if (row >= rows || row >= ROW_LIMIT) res = 2'd0;
        else                                 res = row[1:0];
        return res;
    endfunction

    function automatic t_bus_byte addr_cmd(input logic [5:0] col, input logic [1:0] row);
        t_bus_byte res;
        logic [6:0] addr;
        addr      = 7'({1'b0, col} + row_base(row));
        res.rs    = RS_CMD;
        res.value = CMD_SET_DDRAM | {1'b0, addr};
        return res;
    endfunction

endpackage

`default_nettype wire

// ===== hdl/lcdtw_front.sv =====
// front part: accepts requests, tracks the cursor and config, builds byte jobs
// depends on lcdtw_pkg
`default_nettype none

module lcdtw_front
    import lcdtw_pkg::*;
(
    input  wire logic          i_clk,
    input  wire logic          i_rst_n,
    input  wire logic          i_push,
    input  wire t_req          i_req,
    output logic               o_full,
    input  wire logic          i_cfg_valid,
    input  wire logic [1:0]    i_cfg_index,
    input  wire logic [5:0]    i_cfg_data,
    output logic               o_cfg_ready,
    input  wire t_queue_status i_q_status,
    output logic               o_q_wr,
    output t_job               o_q_job
);

    logic [2:0] r_row_count;
    logic [5:0] r_col_count;
    logic [5:0] r_col, n_col;
    logic [1:0] r_row, n_row;

    logic       accept;
    logic       wrap;
    logic [5:0] wcol;
    logic [1:0] wrow;
    t_bus_byte  wrap_byte;
    t_bus_byte  main_byte;
    logic       emit;

    assign o_full      = i_q_status.full;
    assign o_cfg_ready = 1'b1;
    assign accept      = i_push && !i_q_status.full;

    always_comb begin
        wrap      = r_col >= r_col_count;
        wcol      = r_col;
        wrow      = r_row;
        wrap_byte = addr_cmd(6'd0, 2'd0);
        if (wrap) begin
            wcol      = 6'd0;
            wrow      = fold_row(3'({1'b0, r_row} + 3'd1), r_row_count);
            wrap_byte = addr_cmd(6'd0, wrow);
        end

        n_col     = r_col;
        n_row     = r_row;
        main_byte = '{rs: RS_CMD, value: i_req.byte_value};
        emit      = 1'b1;
        unique case (i_req.req_type)
            REQ_SET_POS: begin
                n_col     = i_req.col_pos;
                n_row     = fold_row({1'b0, i_req.row_pos}, r_row_count);
                main_byte = addr_cmd(n_col, n_row);
            end
            REQ_TEXT: begin
                if (i_req.byte_value == CHAR_NUL) begin
                    emit = 1'b0;
                end else if (i_req.byte_value == CHAR_LF) begin
                    n_col     = wcol;
                    n_row     = fold_row(3'({1'b0, wrow} + 3'd1), r_row_count);
                    main_byte = addr_cmd(n_col, n_row);
                end else if (i_req.byte_value == CHAR_CR) begin
                    n_col     = 6'd0;
                    n_row     = fold_row({1'b0, wrow}, r_row_count);
                    main_byte = addr_cmd(n_col, n_row);
                end else begin
                    n_col     = wcol + 6'd1;
                    n_row     = wrow;
                    main_byte = '{rs: RS_DATA, value: i_req.byte_value};
                end
            end
            REQ_RAW_CMD: main_byte = '{rs: RS_CMD, value: i_req.byte_value};
            REQ_RAW_DATA: main_byte = '{rs: RS_DATA, value: i_req.byte_value};
            default: main_byte = '{rs: RS_DATA, value: i_req.byte_value};
        endcase

        o_q_wr = accept && emit;
        if (i_req.req_type == REQ_TEXT && wrap) begin
            o_q_job = '{two: 1'b1, b0: wrap_byte, b1: main_byte};
        end else begin
            o_q_job = '{two: 1'b0, b0: main_byte, b1: main_byte};
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_row_count <= ROW_COUNT_RESET;
            r_col_count <= COLUMN_COUNT_RESET;
            r_col       <= 6'd0;
            r_row       <= 2'd0;
        end else begin
            if (i_cfg_valid) begin
                if (i_cfg_index == CFG_ROW_COUNT)    r_row_count <= i_cfg_data[2:0];
                if (i_cfg_index == CFG_COLUMN_COUNT) r_col_count <= i_cfg_data;
            end
            if (accept) begin
                r_col <= n_col;
                r_row <= n_row;
            end
        end
    end

endmodule

`default_nettype wire

// ===== hdl/lcdtw_job_fifo.sv =====
// short job queue between the front and back parts
// depends on lcdtw_pkg
`default_nettype none

module lcdtw_job_fifo
    import lcdtw_pkg::*;
(
    input  wire logic    i_clk,
    input  wire logic    i_rst_n,
    input  wire logic    i_wr,
    input  wire t_job    i_wr_job,
    input  wire logic    i_rd,
    output t_job         o_rd_job,
    output t_queue_status o_status
);

    t_job                   r_mem [JOB_DEPTH];
    logic [JOB_PTR_W-1:0]   r_wptr;
    logic [JOB_PTR_W-1:0]   r_rptr;
    logic [JOB_COUNT_W-1:0] r_count;

    logic do_wr;
    logic do_rd;

    assign o_status.full  = r_count == JOB_COUNT_W'(JOB_DEPTH);
    assign o_status.empty = r_count == '0;
    assign o_rd_job       = r_mem[r_rptr];
    assign do_wr          = i_wr && !o_status.full;
    assign do_rd          = i_rd && !o_status.empty;

    always_ff @(posedge i_clk) begin
        if (do_wr) r_mem[r_wptr] <= i_wr_job;
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_wptr  <= '0;
            r_rptr  <= '0;
            r_count <= '0;
        end else begin
            if (do_wr) r_wptr <= r_wptr + JOB_PTR_W'(1);
            if (do_rd) r_rptr <= r_rptr + JOB_PTR_W'(1);
            if (do_wr && !do_rd)      r_count <= r_count + JOB_COUNT_W'(1);
            else if (do_rd && !do_wr) r_count <= r_count - JOB_COUNT_W'(1);
        end
    end

    a_count_bound: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        r_count <= JOB_COUNT_W'(JOB_DEPTH))
        else $error("job queue count past depth");

    a_no_write_full: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        i_wr |-> !o_status.full)
        else $error("job written into full queue");

    a_no_read_empty: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        i_rd |-> !o_status.empty)
        else $error("job read from empty queue");

endmodule

`default_nettype wire

// ===== hdl/lcdtw_back.sv =====
// back part: takes byte jobs and sends them out as tagged nibbles, high first
// depends on lcdtw_pkg
`default_nettype none

module lcdtw_back
    import lcdtw_pkg::*;
(
    input  wire logic          i_clk,
    input  wire logic          i_rst_n,
    input  wire t_queue_status i_q_status,
    input  wire t_job          i_q_job,
    output logic               o_q_rd,
    output t_res               o_res,
    output logic               o_empty,
    input  wire logic          i_pop
);

    logic       r_valid;
    t_job       r_job;
    logic [1:0] r_idx;

    logic       is_last;
    logic       take;
    t_bus_byte  cur;

    always_comb begin
        cur               = r_idx[1] ? r_job.b1 : r_job.b0;
        is_last           = r_idx == (r_job.two ? 2'd3 : 2'd1);
        o_res.reg_select  = cur.rs;
        o_res.nibble      = r_idx[0] ? cur.value[3:0] : cur.value[7:4];
        o_res.last_nibble = is_last;
        o_empty           = !r_valid;
        take              = !r_valid || (i_pop && is_last);
        o_q_rd            = take && !i_q_status.empty;
    end

    always_ff @(posedge i_clk) begin
        if (take) r_job <= i_q_job;
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_valid <= 1'b0;
            r_idx   <= 2'd0;
        end else if (take) begin
            r_valid <= !i_q_status.empty;
            r_idx   <= 2'd0;
        end else if (i_pop) begin
            r_idx <= r_idx + 2'd1;
        end
    end

    a_idx_in_job: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        r_valid |-> (r_job.two || !r_idx[1]))
        else $error("nibble index past a one byte job");

    a_hold_when_stalled: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        r_valid && !i_pop |=> r_valid && $stable(r_idx))
        else $error("waiting nibble changed without a pop");

endmodule

`default_nettype wire

// ===== hdl/char_lcd_text_nibble_writer.sv =====
// top level of the character lcd text writer for a 4-bit bus
// depends on lcdtw_pkg, lcdtw_front, lcdtw_job_fifo, lcdtw_back
`default_nettype none

// Turns text and raw byte requests into RS-tagged nibbles for a 4-bit character
// LCD bus. Requests come in through a queue style port (push/full); nibbles go
// out through another (empty/pop), high nibble of each byte first, with
// last_nibble set on the final nibble of a request. A text character first wraps
// to the next row when the column has reached column_count; newline, carriage
// return and set position each emit a DDRAM address command. A NUL character is
// accepted and produces nothing. A request is accepted whenever the two entry
// job queue has room, so requests may arrive back to back; the output side moves
// one nibble per cycle while popped, so a request costs two nibbles (one byte)
// or four (wrapped character) of output bandwidth, and that nibble serializer
// sets the sustained rate. Configuration writes (index 0 row_count, index 1
// column_count) are always ready and should only be made while the block is idle.

module char_lcd_text_nibble_writer
    import lcdtw_pkg::*;
(
    input  wire logic       i_clk,
    input  wire logic       i_rst_n,
    // request side
    input  wire logic       i_push,
    input  wire t_req       i_req,
    output logic            o_full,
    // nibble side
    output t_res            o_res,
    output logic            o_empty,
    input  wire logic       i_pop,
    // configuration writes
    input  wire logic       i_cfg_valid,
    input  wire logic [1:0] i_cfg_index,
    input  wire logic [5:0] i_cfg_data,
    output logic            o_cfg_ready
);

    // front to queue
    logic          q_wr;
    t_job          q_wr_job;
    // queue to back
    logic          q_rd;
    t_job          q_rd_job;
    t_queue_status q_status;

    // request decode, cursor tracking and config registers
    lcdtw_front u_front (
        .i_clk       (i_clk),
        .i_rst_n     (i_rst_n),
        .i_push      (i_push),
        .i_req       (i_req),
        .o_full      (o_full),
        .i_cfg_valid (i_cfg_valid),
        .i_cfg_index (i_cfg_index),
        .i_cfg_data  (i_cfg_data),
        .o_cfg_ready (o_cfg_ready),
        .i_q_status  (q_status),
        .o_q_wr      (q_wr),
        .o_q_job     (q_wr_job)
    );

    // decouples request acceptance from nibble output stalls
    lcdtw_job_fifo u_fifo (
        .i_clk    (i_clk),
        .i_rst_n  (i_rst_n),
        .i_wr     (q_wr),
        .i_wr_job (q_wr_job),
        .i_rd     (q_rd),
        .o_rd_job (q_rd_job),
        .o_status (q_status)
    );

    // nibble serializer, holds the nibble on offer until popped
    lcdtw_back u_back (
        .i_clk      (i_clk),
        .i_rst_n    (i_rst_n),
        .i_q_status (q_status),
        .i_q_job    (q_rd_job),
        .o_q_rd     (q_rd),
        .o_res      (o_res),
        .o_empty    (o_empty),
        .i_pop      (i_pop)
    );

endmodule

`default_nettype wire
